FILE: hdl/futex_wait_table_defines.svh
// assertion macros
`ifndef FUTEX_WAIT_TABLE_DEFINES_SVH
`define FUTEX_WAIT_TABLE_DEFINES_SVH
`ifndef ASSERT_OFF
`define FWT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FWT_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FWT_ASSERT_IMP(label, clk, rstn, ante, cons)
`define FWT_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: hdl/fwt_pkg.sv
`timescale 1ns / 1ps
package fwt_pkg;
    localparam int WAITER_SLOTS_DEF = 16;
    localparam int PROC_ID_WIDTH_DEF = 8;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        MODE_WAIT = 3'd0, MODE_WAIT_BITSET = 3'd1, MODE_WAKE = 3'd2,
        MODE_WAKE_BITSET = 3'd3, MODE_REQUEUE = 3'd4, MODE_CLEANUP = 3'd5,
        MODE_RSVD6 = 3'd6, MODE_RSVD7 = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_CHANGED = 3'd1, ST_INVALID = 3'd2,
        ST_NOSLOT = 3'd3, ST_UNSUPPORTED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_STATUS = 2'd0, OP_WAIT = 2'd1, OP_WAKE = 2'd2, OP_CLEANUP = 2'd3
    } op_t;

    // classified command from front to back
    typedef struct packed {
        op_t         op;
        status_t     status;
        logic [31:0] address;
        logic [31:0] limit;
        logic [31:0] bitset;
        logic [15:0] proc;
    } cmd_t;
endpackage

FILE: hdl/fwt_front.sv
`timescale 1ns / 1ps
module fwt_front #(
    parameter int PROC_ID_WIDTH = fwt_pkg::PROC_ID_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [2:0]   mode,
    input  logic [31:0]  address,
    input  logic [31:0]  argument,
    input  logic [31:0]  current_value,
    input  logic [31:0]  bitset,
    input  logic [7:0]   proc_id,
    output logic         cmd_valid,
    input  logic         cmd_ready,
    output fwt_pkg::cmd_t cmd
);
    localparam int PW = (PROC_ID_WIDTH < 8) ? PROC_ID_WIDTH : 8;
    // two-entry queue
    fwt_pkg::cmd_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, wr_reg;
    fwt_pkg::cmd_t c;
    logic [15:0] p;
    logic push, pop;

    always_comb begin
        p = '0;
        p[PW-1:0] = proc_id[PW-1:0];
        c = '0;
        c.address = address;
        c.proc = p;
        c.bitset = fwt_pkg::ALL_ONES;
        c.status = fwt_pkg::ST_OK;
        unique case (fwt_pkg::mode_t'(mode))
            fwt_pkg::MODE_WAIT, fwt_pkg::MODE_WAIT_BITSET: begin
                if (mode == fwt_pkg::MODE_WAIT_BITSET && bitset != 32'd0) c.bitset = bitset;
                if (p == 16'd0 || address == 32'd0) begin
                    c.op = fwt_pkg::OP_STATUS; c.status = fwt_pkg::ST_INVALID;
                end else if (current_value != argument) begin
                    c.op = fwt_pkg::OP_STATUS; c.status = fwt_pkg::ST_CHANGED;
                end else c.op = fwt_pkg::OP_WAIT;
            end
            fwt_pkg::MODE_WAKE, fwt_pkg::MODE_WAKE_BITSET: begin
                if (mode == fwt_pkg::MODE_WAKE_BITSET && bitset != 32'd0) c.bitset = bitset;
                c.limit = argument[31] ? 32'd0 : argument;
                if (address == 32'd0) begin
                    c.op = fwt_pkg::OP_STATUS; c.status = fwt_pkg::ST_INVALID;
                end else c.op = fwt_pkg::OP_WAKE;
            end
            fwt_pkg::MODE_REQUEUE: c.op = fwt_pkg::OP_STATUS;
            fwt_pkg::MODE_CLEANUP: c.op = (p == 16'd0) ? fwt_pkg::OP_STATUS
                                                       : fwt_pkg::OP_CLEANUP;
            default: begin
                c.op = fwt_pkg::OP_STATUS; c.status = fwt_pkg::ST_UNSUPPORTED;
            end
        endcase
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = cmd_valid && cmd_ready;
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0; rd_reg <= 1'b0; wr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wr_reg <= ~wr_reg;
            if (pop) rd_reg <= ~rd_reg;
        end
        if (push) q_reg[wr_reg] <= c;
    end
endmodule

FILE: hdl/fwt_back.sv
`timescale 1ns / 1ps
`include "futex_wait_table_defines.svh"
module fwt_back #(
    parameter int WAITER_SLOTS = fwt_pkg::WAITER_SLOTS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  fwt_pkg::cmd_t cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          out_last,
    output logic [7:0]    out_proc,
    output logic [2:0]    out_status,
    output logic [5:0]    out_count
);
    localparam int IW = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
    localparam int CW = $clog2(WAITER_SLOTS + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINAL} state_t;
    state_t state_reg;

    logic [WAITER_SLOTS-1:0] active_reg;
    logic [31:0] addr_mem [WAITER_SLOTS];
    logic [15:0] proc_mem [WAITER_SLOTS];
    logic [31:0] bits_mem [WAITER_SLOTS];

    fwt_pkg::cmd_t cur_reg;
    logic [CW-1:0] idx_reg;
    logic [5:0]    woken_reg;
    logic [2:0]    stat_reg;
    logic ov_reg, last_reg;
    logic [7:0] proc_reg;
    logic [5:0] cnt_reg;

    logic [IW-1:0] ix;
    logic hit, free_found, done_limit;
    logic [IW-1:0] free_ix;
    logic out_free;
    logic ov_set, ov_next;

    assign ix = idx_reg[IW-1:0];
    assign hit = active_reg[ix] && addr_mem[ix] == cur_reg.address
                 && (bits_mem[ix] & cur_reg.bitset) != 32'd0;
    assign done_limit = {26'd0, woken_reg} >= cur_reg.limit;
    assign out_free = !ov_reg || out_ready;
    assign cmd_ready = (state_reg == S_IDLE) && out_free;

    always_comb begin
        free_found = 1'b0;
        free_ix = '0;
        for (int i = WAITER_SLOTS - 1; i >= 0; i--) begin
            if (!active_reg[i]) begin
                free_found = 1'b1; free_ix = IW'(i);
            end
        end
    end

    // a new beat is loaded only when the output register is free
    always_comb begin
        ov_set = 1'b0;
        unique case (state_reg)
            S_IDLE:  ov_set = cmd_valid && cmd_ready && cmd.op != fwt_pkg::OP_WAKE;
            S_SCAN:  ov_set = !(idx_reg == CW'(WAITER_SLOTS) || done_limit) && hit
                              && out_free;
            S_FINAL: ov_set = out_free;
            default: ov_set = 1'b0;
        endcase
        ov_next = ov_set || (ov_reg && !out_ready);
    end

    assign out_valid = ov_reg;
    assign out_last = last_reg;
    assign out_proc = proc_reg;
    assign out_status = stat_reg;
    assign out_count = cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; active_reg <= '0; ov_reg <= 1'b0;
            idx_reg <= '0; woken_reg <= '0;
        end else begin
            ov_reg <= ov_next;
            unique case (state_reg)
                S_IDLE: if (cmd_valid && cmd_ready) begin
                    cur_reg <= cmd;
                    idx_reg <= '0; woken_reg <= '0;
                    case (cmd.op)
                        fwt_pkg::OP_STATUS: begin
                            last_reg <= 1'b1; proc_reg <= '0;
                            stat_reg <= cmd.status; cnt_reg <= '0;
                        end
                        fwt_pkg::OP_WAIT: begin
                            last_reg <= 1'b1; proc_reg <= '0;
                            cnt_reg <= '0;
                            if (free_found) begin
                                active_reg[free_ix] <= 1'b1;
                                addr_mem[free_ix] <= cmd.address;
                                proc_mem[free_ix] <= cmd.proc;
                                bits_mem[free_ix] <= cmd.bitset;
                                stat_reg <= fwt_pkg::ST_OK;
                            end else stat_reg <= fwt_pkg::ST_NOSLOT;
                        end
                        fwt_pkg::OP_CLEANUP: begin
                            for (int i = 0; i < WAITER_SLOTS; i++)
                                if (active_reg[i] && proc_mem[i] == cmd.proc)
                                    active_reg[i] <= 1'b0;
                            last_reg <= 1'b1; proc_reg <= '0;
                            stat_reg <= fwt_pkg::ST_OK; cnt_reg <= '0;
                        end
                        default: state_reg <= S_SCAN;
                    endcase
                end
                S_SCAN: begin
                    if (idx_reg == CW'(WAITER_SLOTS) || done_limit)
                        state_reg <= S_FINAL;
                    else if (hit) begin
                        if (out_free) begin
                            active_reg[ix] <= 1'b0;
                            last_reg <= 1'b0;
                            proc_reg <= proc_mem[ix][7:0];
                            stat_reg <= fwt_pkg::ST_OK; cnt_reg <= '0;
                            woken_reg <= woken_reg + 6'd1;
                            idx_reg <= idx_reg + CW'(1);
                        end
                    end else idx_reg <= idx_reg + CW'(1);
                end
                S_FINAL: if (out_free) begin
                    last_reg <= 1'b1; proc_reg <= '0;
                    stat_reg <= fwt_pkg::ST_OK; cnt_reg <= woken_reg;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `FWT_ASSERT_NXT(a_hold, aclk, aresetn, out_valid && !out_ready, out_valid && $stable(out_proc))
    `FWT_ASSERT_IMP(a_nocmd, aclk, aresetn, state_reg != S_IDLE, !cmd_ready)
    `FWT_ASSERT_IMP(a_cnt, aclk, aresetn, out_valid && !out_last, out_count == 6'd0)
endmodule

FILE: hdl/futex_wait_table.sv
`timescale 1ns / 1ps
// path: a wait, cleanup or status item passes through the front-end queue into the back-end
// output register; a wake count beat follows the back-end scan of the slots
// acceptance: the back end takes a new wait, cleanup or status item once its output register
// is free; a wake holds off new items until its scan, one slot a cycle unless a hit meets a
// stalled output, and its count beat are done; reset: aresetn low clears every slot active
// bit, the queue and the output valid bit; slot contents are not cleared
module futex_wait_table #(
    parameter int WAITER_SLOTS = fwt_pkg::WAITER_SLOTS_DEF,
    parameter int PROC_ID_WIDTH = fwt_pkg::PROC_ID_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode[2:0], address[34:3], argument[66:35], current_value[98:67],
    // bitset[130:99], proc_id[138:131], zero fill
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic         m_tlast,
    // woken_proc[7:0], status[10:8], woken_count[16:11], zero fill
    output logic [23:0]  m_tdata
);
    logic cmd_valid, cmd_ready;
    fwt_pkg::cmd_t cmd;
    logic [7:0] proc;
    logic [2:0] st;
    logic [5:0] cnt;

    fwt_front #(.PROC_ID_WIDTH(PROC_ID_WIDTH)) u_front (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready),
        .mode(s_tdata[2:0]), .address(s_tdata[34:3]), .argument(s_tdata[66:35]),
        .current_value(s_tdata[98:67]), .bitset(s_tdata[130:99]),
        .proc_id(s_tdata[138:131]), .cmd_valid, .cmd_ready, .cmd
    );

    fwt_back #(.WAITER_SLOTS(WAITER_SLOTS)) u_back (
        .aclk, .aresetn, .cmd_valid, .cmd_ready, .cmd,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_last(m_tlast),
        .out_proc(proc), .out_status(st), .out_count(cnt)
    );

    assign m_tdata = {7'd0, cnt, st, proc};
endmodule
